/* hdl/otce_pkg.sv */
// ----------------------------------------------------------------------------
// otce_pkg: shared types and constants for the OLED text cursor engine
// Result record, ALU request/response, sequencer states and the glyph
// stream decode used while a printable character is being sent.
// ----------------------------------------------------------------------------
package otce_pkg;

  // Cursor limits and steps
  localparam logic [7:0] COL_LIMIT     = 8'd120;
  localparam logic [7:0] MAX_PAGE_SM   = 8'd7;
  localparam logic [7:0] MAX_PAGE_LG   = 8'd6;
  localparam logic [7:0] TAB_SM        = 8'd24;
  localparam logic [7:0] TAB_LG        = 8'd32;
  localparam logic [7:0] ADV_SM        = 8'd6;
  localparam logic [7:0] ADV_LG        = 8'd8;

  // Character codes
  localparam logic [6:0] CH_TAB        = 7'd9;
  localparam logic [6:0] CH_LF         = 7'd10;
  localparam logic [6:0] CH_CR         = 7'd13;
  localparam logic [6:0] CH_SPACE      = 7'd32;

  // Display commands
  localparam logic [3:0] CMD_PAGE_HI   = 4'hB;
  localparam logic [3:0] CMD_COLH_HI   = 4'h1;

  // Position within the byte stream of one glyph
  localparam logic [4:0] LAST_SM       = 5'd8;
  localparam logic [4:0] LAST_LG       = 5'd21;
  localparam logic [4:0] POS_LEN       = 5'd3;
  localparam logic [4:0] POS2_START    = 5'd11;
  localparam logic [4:0] DATA2_START   = 5'd14;
  localparam logic [4:0] DATA2_OFFSET  = 5'd6;

  // Register map
  localparam int unsigned  PADDR_W       = 3;
  localparam logic [PADDR_W-1:0] REG_FONT_MODE = 3'd0;

  typedef enum logic {
    ALU_ADD,
    ALU_SUB
  } alu_op_e;

  typedef struct packed {
    alu_op_e    op;
    logic [7:0] a;
    logic [7:0] b;
  } alu_req_t;

  typedef struct packed {
    logic [7:0] sum;
    logic       carry;
  } alu_rsp_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_WRAP_CMP,
    ST_PAGE_ADD,
    ST_STOP_CMP,
    ST_DECODE,
    ST_EMIT,
    ST_ADVANCE
  } seq_state_e;

  typedef struct packed {
    logic       is_data;
    logic [7:0] command_byte;
    logic [6:0] glyph_index;
    logic [3:0] glyph_byte;
    logic       last;
  } result_t;

  // One entry of the glyph stream: three position commands, glyph bytes,
  // and for the large font a second position block for the lower page.
  function automatic result_t otce_result(input logic [4:0] idx,
                                          input logic       font_lg,
                                          input logic [7:0] col,
                                          input logic [3:0] page,
                                          input logic [6:0] gidx);
    result_t    r;
    logic       is_pos;
    logic [4:0] k;
    logic [3:0] p;
    logic [3:0] gb;
    r      = '0;
    is_pos = 1'b0;
    k      = idx;
    p      = page;
    gb     = 4'(idx - POS_LEN);
    if (idx < POS_LEN) begin
      is_pos = 1'b1;
    end else if (font_lg && (idx >= POS2_START) && (idx < DATA2_START)) begin
      is_pos = 1'b1;
      k      = idx - POS2_START;
      p      = 4'(page + 4'd1);
    end else if (font_lg && (idx >= DATA2_START)) begin
      gb     = 4'(idx - DATA2_OFFSET);
    end
    if (is_pos) begin
      case (k[1:0])
        2'd0:    r.command_byte = {CMD_PAGE_HI, 4'(4'd7 - p)};
        2'd1:    r.command_byte = {4'h0, col[3:0]};
        default: r.command_byte = {CMD_COLH_HI, col[7:4]};
      endcase
    end else begin
      r.is_data     = 1'b1;
      r.glyph_index = gidx;
      r.glyph_byte  = gb;
    end
    r.last = font_lg ? (idx == LAST_LG) : (idx == LAST_SM);
    return r;
  endfunction

endpackage

/* hdl/otce_alu.sv */
// ----------------------------------------------------------------------------
// otce_alu: shared 8-bit add/subtract unit
// Used by the sequencer for cursor arithmetic and limit compares.
// ----------------------------------------------------------------------------
module otce_alu import otce_pkg::*; (
  input  alu_req_t req_i,
  output alu_rsp_t rsp_o
);

  logic [7:0] b_eff;
  logic [8:0] total;

  // a + b, or a + ~b + 1; carry high on subtract means no borrow (a >= b)
  assign b_eff = (req_i.op == ALU_SUB) ? ~req_i.b : req_i.b;
  assign total = {1'b0, req_i.a} + {1'b0, b_eff} + {8'd0, (req_i.op == ALU_SUB)};

  assign rsp_o.sum   = total[7:0];
  assign rsp_o.carry = total[8];

endmodule

/* hdl/otce_apb_regs.sv */
// ----------------------------------------------------------------------------
// otce_apb_regs: APB register file
// Holds the font mode register; always ready, zero wait states.
// ----------------------------------------------------------------------------
module otce_apb_regs import otce_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  output logic               font_mode_o
);

  logic font_mode_q;
  logic font_mode_d;
  logic wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && (paddr == REG_FONT_MODE);

  // Register write
  always_comb begin
    font_mode_d = font_mode_q;
    if (wr_en) begin
      font_mode_d = pwdata[0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      font_mode_q <= 1'b0;
    end else begin
      font_mode_q <= font_mode_d;
    end
  end

  // Read-back
  assign prdata      = (paddr == REG_FONT_MODE) ? {31'd0, font_mode_q} : 32'd0;
  assign font_mode_o = font_mode_q;

endmodule

/* hdl/otce_seq.sv */
// ----------------------------------------------------------------------------
// otce_seq: cursor sequencer and result register
// Steps through wrap, stop and control-character handling with the shared
// ALU, then streams the glyph transactions one per cycle into a result
// register while the output does not stall.
// ----------------------------------------------------------------------------
module otce_seq import otce_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       font_mode_i,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic       action_i,
  input  logic [6:0] character_i,
  input  logic [6:0] set_column_i,
  input  logic [2:0] set_page_i,
  output alu_req_t   alu_req_o,
  input  alu_rsp_t   alu_rsp_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output result_t    out_res_o
);

  seq_state_e state_q, state_d;
  logic [7:0] col_q, col_d;
  logic [3:0] page_q, page_d;
  logic       stopped_q, stopped_d;
  logic [6:0] ch_q, ch_d;
  logic [4:0] idx_q, idx_d;
  logic       out_valid_q, out_valid_d;
  result_t    out_res_q, out_res_d;

  logic       in_fire;
  logic       slot_free;
  logic       emit_fire;
  logic       font_lg;
  logic [6:0] gidx;
  result_t    cur_res;

  assign font_lg   = font_mode_i;
  assign in_stall_o = (state_q != ST_IDLE);
  assign in_fire   = in_valid_i && !in_stall_o;
  assign slot_free = !out_valid_q || !out_stall_i;
  assign emit_fire = (state_q == ST_EMIT) && slot_free;
  assign gidx      = 7'(ch_q - CH_SPACE);
  assign cur_res   = otce_result(idx_q, font_lg, col_q, page_q, gidx);

  // Next state, cursor updates and ALU operand selection
  always_comb begin
    state_d   = state_q;
    col_d     = col_q;
    page_d    = page_q;
    stopped_d = stopped_q;
    ch_d      = ch_q;
    idx_d     = idx_q;
    alu_req_o = '{op: ALU_ADD, a: col_q, b: 8'd0};
    case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          if (action_i) begin
            col_d     = {1'b0, set_column_i};
            page_d    = {1'b0, set_page_i};
            stopped_d = 1'b0;
          end else begin
            ch_d    = character_i;
            state_d = ST_WRAP_CMP;
          end
        end
      end
      ST_WRAP_CMP: begin
        // column > 120 when 120 - column borrows
        alu_req_o = '{op: ALU_SUB, a: COL_LIMIT, b: col_q};
        if (!alu_rsp_i.carry) begin
          col_d   = 8'd0;
          state_d = ST_PAGE_ADD;
        end else begin
          state_d = ST_STOP_CMP;
        end
      end
      ST_PAGE_ADD: begin
        alu_req_o = '{op: ALU_ADD, a: {4'd0, page_q}, b: font_lg ? 8'd2 : 8'd1};
        page_d    = alu_rsp_i.sum[3:0];
        state_d   = ST_STOP_CMP;
      end
      ST_STOP_CMP: begin
        alu_req_o = '{op: ALU_SUB, a: font_lg ? MAX_PAGE_LG : MAX_PAGE_SM,
                      b: {4'd0, page_q}};
        if (!alu_rsp_i.carry) begin
          page_d    = 4'd0;
          stopped_d = 1'b1;
          state_d   = ST_IDLE;
        end else if (stopped_q) begin
          state_d = ST_IDLE;
        end else begin
          state_d = ST_DECODE;
        end
      end
      ST_DECODE: begin
        state_d = ST_IDLE;
        idx_d   = 5'd0;
        if (ch_q == CH_CR) begin
          col_d = 8'd0;
        end else if (ch_q == CH_LF) begin
          alu_req_o = '{op: ALU_ADD, a: {4'd0, page_q}, b: font_lg ? 8'd2 : 8'd1};
          page_d    = alu_rsp_i.sum[3:0];
        end else if (ch_q == CH_TAB) begin
          alu_req_o = '{op: ALU_ADD, a: col_q, b: font_lg ? TAB_LG : TAB_SM};
          col_d     = alu_rsp_i.sum;
        end else if (ch_q >= CH_SPACE) begin
          state_d = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (emit_fire) begin
          if (cur_res.last) begin
            state_d = ST_ADVANCE;
          end else begin
            idx_d = idx_q + 5'd1;
          end
        end
      end
      ST_ADVANCE: begin
        alu_req_o = '{op: ALU_ADD, a: col_q, b: font_lg ? ADV_LG : ADV_SM};
        col_d     = alu_rsp_i.sum;
        state_d   = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      col_q     <= 8'd0;
      page_q    <= 4'd0;
      stopped_q <= 1'b0;
      idx_q     <= 5'd0;
    end else begin
      state_q   <= state_d;
      col_q     <= col_d;
      page_q    <= page_d;
      stopped_q <= stopped_d;
      idx_q     <= idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ch_q <= ch_d;
  end

  // Result register: loads whenever it is empty or being taken
  always_comb begin
    out_valid_d = out_valid_q;
    out_res_d   = out_res_q;
    if (emit_fire) begin
      out_valid_d = 1'b1;
      out_res_d   = cur_res;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_res_q <= out_res_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_res_o   = out_res_q;

`ifndef ASSERT_OFF
  // Glyph streaming never runs while output is suppressed
  a_emit_not_stopped: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_EMIT) |-> !stopped_q)
    else $error("glyph stream while stopped");

  // Position commands are only built for a page on screen
  a_page_on_screen: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_EMIT) |-> (font_lg ? (page_q <= 4'd6) : (page_q <= 4'd7)))
    else $error("emitting on an off-screen page");

  // Stream index stays inside the glyph
  a_idx_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_EMIT) |-> (font_lg ? (idx_q <= LAST_LG) : (idx_q <= LAST_SM)))
    else $error("glyph index counter overran");

  // The final transaction of a glyph is followed by the column advance
  a_last_then_adv: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (emit_fire && cur_res.last) |=> (state_q == ST_ADVANCE) && out_valid_q && out_res_q.last)
    else $error("last transaction not followed by cursor advance");
`endif

endmodule

/* hdl/oled_text_cursor_engine.sv */
// ----------------------------------------------------------------------------
// oled_text_cursor_engine: page-mode OLED text console
// Keeps a text cursor and turns characters into display commands and font
// ROM byte references.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i / in_stall_o) carries one action per
//   transaction: put a character, or set the cursor and clear the stop flag.
//   Output channel (out_valid_o / out_stall_i) carries one display byte per
//   transaction: a command byte or a glyph byte reference; last_o marks the
//   final one caused by a character.
//   A set-cursor transaction is applied when accepted. A character first
//   passes cursor handling in the shared add/subtract unit (wrap test,
//   page advance on a wrap, stop test, decode); a printable one then streams
//   9 (6x8 font) or 22 (8x16 font) transactions at one per cycle while the
//   output does not stall, and then the column advance follows.
//   in_stall_o stays high until the sequencer returns to idle. A stall on the
//   output holds the result register and pauses the stream; the last result
//   may wait there while the next input is accepted. Reset clears the cursor,
//   the stop flag and the font mode (6x8). The user writes font_mode over
//   the APB port only while the block is idle; the block does not enforce it.
// ----------------------------------------------------------------------------
module oled_text_cursor_engine import otce_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  // APB configuration port
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  // Input channel
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic               action_i,
  input  logic [6:0]         character_i,
  input  logic [6:0]         set_column_i,
  input  logic [2:0]         set_page_i,
  // Output channel
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic               is_data_o,
  output logic [7:0]         command_byte_o,
  output logic [6:0]         glyph_index_o,
  output logic [3:0]         glyph_byte_o,
  output logic               last_o
);

  logic     font_mode;
  alu_req_t alu_req;
  alu_rsp_t alu_rsp;
  result_t  out_res;

  otce_apb_regs u_regs (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready),
    .font_mode_o (font_mode)
  );

  otce_alu u_alu (
    .req_i (alu_req),
    .rsp_o (alu_rsp)
  );

  otce_seq u_seq (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .font_mode_i  (font_mode),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .action_i     (action_i),
    .character_i  (character_i),
    .set_column_i (set_column_i),
    .set_page_i   (set_page_i),
    .alu_req_o    (alu_req),
    .alu_rsp_i    (alu_rsp),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .out_res_o    (out_res)
  );

  // Result fields
  assign is_data_o      = out_res.is_data;
  assign command_byte_o = out_res.command_byte;
  assign glyph_index_o  = out_res.glyph_index;
  assign glyph_byte_o   = out_res.glyph_byte;
  assign last_o         = out_res.last;

endmodule

/* test/oled_text_cursor_engine_test.sv */
// ----------------------------------------------------------------------------
// oled_text_cursor_engine_test: self-checking bench for the OLED text console
// Sends cursor and character transactions through the valid/stall input
// channel, predicts every display byte from a local cursor model and checks
// each output transaction in order. The font mode is switched over APB
// between phases, and both channels see random idle and stall bursts.
// ----------------------------------------------------------------------------
module oled_text_cursor_engine_test;
  timeunit 1ns;
  timeprecision 1ps;
  import otce_pkg::*;

  localparam int unsigned SETTLE_CYCLES  = 12;
  localparam int unsigned WATCHDOG_LIMIT = 2000;
  localparam int unsigned PHASE_ITEMS    = 60;

  typedef enum logic {
    ACT_PUT_CHAR,
    ACT_SET_CURSOR
  } cursor_action_e;

  typedef enum logic {
    FONT_SMALL,
    FONT_LARGE
  } font_e;

  typedef struct packed {
    cursor_action_e action;
    logic [6:0]     character;
    logic [6:0]     set_column;
    logic [2:0]     set_page;
  } cursor_cmd_t;

  // Clock and reset
  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // APB and channel signals
  logic                psel    = 1'b0;
  logic                penable = 1'b0;
  logic                pwrite  = 1'b0;
  logic [PADDR_W-1:0]  paddr   = '0;
  logic [31:0]         pwdata  = '0;
  logic [31:0]         prdata;
  logic                pready;

  logic                in_valid_i  = 1'b0;
  logic                in_stall_o;
  cursor_cmd_t         cmd_q       = '0;
  logic                out_valid_o;
  logic                out_stall_i = 1'b0;
  logic                is_data_o;
  logic [7:0]          command_byte_o;
  logic [6:0]          glyph_index_o;
  logic [3:0]          glyph_byte_o;
  logic                last_o;

  oled_text_cursor_engine uut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .action_i       (cmd_q.action),
    .character_i    (cmd_q.character),
    .set_column_i   (cmd_q.set_column),
    .set_page_i     (cmd_q.set_page),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .is_data_o      (is_data_o),
    .command_byte_o (command_byte_o),
    .glyph_index_o  (glyph_index_o),
    .glyph_byte_o   (glyph_byte_o),
    .last_o         (last_o)
  );

  // Bench state
  cursor_cmd_t pending_cmds[$];
  result_t     display_bytes[$];
  int unsigned queued_total   = 0;
  int unsigned accepted_total = 0;
  int unsigned mismatches     = 0;
  int unsigned send_gap       = 0;
  int unsigned stall_left     = 0;
  int unsigned stuck_cycles   = 0;
  logic        quiet          = 1'b0;

  // Local copy of the cursor state and font mode
  font_e       font_sel  = FONT_SMALL;
  logic [7:0]  cur_col   = '0;
  logic [3:0]  cur_page  = '0;
  logic        halted    = 1'b0;

  function automatic void push_byte(input logic is_data, input logic [7:0] cmd,
                                    input logic [6:0] gidx, input logic [3:0] gbyte,
                                    input logic is_last);
    result_t r;
    r.is_data      = is_data;
    r.command_byte = cmd;
    r.glyph_index  = gidx;
    r.glyph_byte   = gbyte;
    r.last         = is_last;
    display_bytes.push_back(r);
  endfunction

  // Page, column-low and column-high commands
  function automatic void push_position(input logic [7:0] col, input logic [3:0] pg);
    push_byte(1'b0, {CMD_PAGE_HI, 4'(4'd7 - pg)}, '0, '0, 1'b0);
    push_byte(1'b0, {4'h0, col[3:0]}, '0, '0, 1'b0);
    push_byte(1'b0, {CMD_COLH_HI, col[7:4]}, '0, '0, 1'b0);
  endfunction

  // Cursor update and expected display bytes for one accepted transaction
  function automatic void predict_display_bytes(input cursor_cmd_t c);
    logic [3:0] step;
    logic [7:0] max_page;
    logic [7:0] col;
    logic [6:0] gidx;
    if (c.action == ACT_SET_CURSOR) begin
      cur_col  = {1'b0, c.set_column};
      cur_page = {1'b0, c.set_page};
      halted   = 1'b0;
      return;
    end
    step     = (font_sel == FONT_LARGE) ? 4'd2 : 4'd1;
    max_page = (font_sel == FONT_LARGE) ? MAX_PAGE_LG : MAX_PAGE_SM;
    // wrap and full-screen checks apply even when already halted
    if (cur_col > COL_LIMIT) begin
      cur_col  = '0;
      cur_page = 4'(cur_page + step);
    end
    if ({4'd0, cur_page} > max_page) begin
      cur_page = '0;
      halted   = 1'b1;
    end
    if (halted) return;
    if (c.character == CH_CR) begin
      cur_col = '0;
      return;
    end
    if (c.character == CH_LF) begin
      cur_page = 4'(cur_page + step);
      return;
    end
    if (c.character == CH_TAB) begin
      cur_col = 8'(cur_col + ((font_sel == FONT_LARGE) ? TAB_LG : TAB_SM));
      return;
    end
    if (c.character < CH_SPACE) return;
    gidx = c.character - CH_SPACE;
    col  = cur_col;
    push_position(col, cur_page);
    if (font_sel == FONT_LARGE) begin
      for (int i = 0; i < 8; i++) push_byte(1'b1, '0, gidx, 4'(i), 1'b0);
      push_position(col, 4'(cur_page + 4'd1));
      for (int i = 8; i < 16; i++) push_byte(1'b1, '0, gidx, 4'(i), i == 15);
      cur_col = 8'(col + ADV_LG);
    end else begin
      for (int i = 0; i < 6; i++) push_byte(1'b1, '0, gidx, 4'(i), i == 5);
      cur_col = 8'(col + ADV_SM);
    end
  endfunction

  // Input driver: random idle bursts, payload held while stalled
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) begin
        predict_display_bytes(cmd_q);
        accepted_total++;
      end
      if (!in_valid_i || !in_stall_o) begin
        if (send_gap != 0) begin
          send_gap--;
          in_valid_i <= 1'b0;
        end else if (!quiet && $urandom_range(0, 11) == 0) begin
          send_gap = $urandom_range(0, 13);
          in_valid_i <= 1'b0;
        end else if (pending_cmds.size() != 0) begin
          cmd_q      <= pending_cmds.pop_front();
          in_valid_i <= 1'b1;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  function automatic void check_field(input string name, input int unsigned exp_v,
                                      input int unsigned got);
    if (exp_v != got) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, exp_v, got);
      mismatches++;
    end
  endfunction

  // Output monitor and stall generator
  always @(posedge clk_i) begin
    result_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (display_bytes.size() == 0) begin
        $error("unexpected output transaction: command 0x%0h glyph %0d byte %0d",
               command_byte_o, glyph_index_o, glyph_byte_o);
        mismatches++;
      end else begin
        want = display_bytes.pop_front();
        check_field("is_data", want.is_data, is_data_o);
        check_field("command_byte", want.command_byte, command_byte_o);
        check_field("glyph_index", want.glyph_index, glyph_index_o);
        check_field("glyph_byte", want.glyph_byte, glyph_byte_o);
        check_field("last", want.last, last_o);
      end
    end
    if (stall_left != 0) begin
      stall_left--;
      out_stall_i <= 1'b1;
    end else if (!quiet && $urandom_range(0, 9) == 0) begin
      stall_left = $urandom_range(0, 13);
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= 1'b0;
    end
  end

  // Watchdog: cycles without any transaction on either channel
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      stuck_cycles <= 0;
    end else if (stuck_cycles == WATCHDOG_LIMIT) begin
      $display("oled_text_cursor_engine_test: errors");
      $finish;
    end else begin
      stuck_cycles <= stuck_cycles + 1;
    end
  end

  function automatic void enqueue(input cursor_cmd_t c);
    pending_cmds.push_back(c);
    queued_total++;
  endfunction

  function automatic void put_char(input logic [6:0] ch);
    cursor_cmd_t c;
    c           = cursor_cmd_t'(18'($urandom));
    c.action    = ACT_PUT_CHAR;
    c.character = ch;
    enqueue(c);
  endfunction

  function automatic void set_cursor(input logic [6:0] col, input logic [2:0] pg);
    cursor_cmd_t c;
    c            = cursor_cmd_t'(18'($urandom));
    c.action     = ACT_SET_CURSOR;
    c.set_column = col;
    c.set_page   = pg;
    enqueue(c);
  endfunction

  // Mostly printable text, some cursor moves, a little control noise
  function automatic cursor_cmd_t random_cmd();
    cursor_cmd_t c;
    int unsigned sel;
    c      = cursor_cmd_t'(18'($urandom));
    c.action = ACT_PUT_CHAR;
    sel    = $urandom_range(0, 99);
    if (sel < 66) begin
      c.character = 7'($urandom_range(32, 127));
    end else if (sel < 72) begin
      c.character = CH_CR;
    end else if (sel < 77) begin
      c.character = CH_LF;
    end else if (sel < 82) begin
      c.character = CH_TAB;
    end else if (sel < 86) begin
      c.character = 7'($urandom_range(0, 31));
    end else begin
      c.action = ACT_SET_CURSOR;
      if ($urandom_range(0, 1) == 0) c.set_column = 7'($urandom_range(100, 127));
    end
    return c;
  endfunction

  // Wait until every queued transaction is accepted and every byte has come
  task automatic drain();
    do @(posedge clk_i);
    while (accepted_total != queued_total || display_bytes.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // APB write: setup cycle, then access cycle
  task automatic write_font(input font_e f);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= REG_FONT_MODE;
    pwdata  <= {31'd0, f};
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel     <= 1'b0;
    penable  <= 1'b0;
    pwrite   <= 1'b0;
    font_sel = f;
  endtask

  // Stimulus sequence
  initial begin
    font_e       phase_font[5];
    cursor_cmd_t c;
    int unsigned counted;
    phase_font = '{FONT_LARGE, FONT_SMALL, FONT_LARGE, FONT_SMALL, FONT_LARGE};
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    // small font: printable extremes, cursor controls, ignored codes
    put_char(7'd65);
    put_char(CH_SPACE);
    put_char(7'd127);
    put_char(CH_CR);
    put_char(CH_TAB);
    put_char(CH_LF);
    put_char(7'd0);
    put_char(7'd31);
    // column wrap off the bottom page halts output until the cursor is set
    set_cursor(7'd127, 3'd7);
    put_char(7'd120);
    put_char(7'd121);
    set_cursor(7'd120, 3'd7);
    put_char(7'd48);
    set_cursor(7'd0, 3'd0);
    drain();

    // large font: two-page glyphs, wrap past the last page, LF off screen halts TAB
    write_font(FONT_LARGE);
    put_char(7'd87);
    set_cursor(7'd121, 3'd5);
    put_char(7'd97);
    set_cursor(7'd0, 3'd6);
    put_char(7'd90);
    put_char(CH_LF);
    put_char(CH_TAB);
    put_char(7'd33);
    set_cursor(7'd0, 3'd0);
    drain();

    // random phases, font changed between them with the cursor kept
    foreach (phase_font[p]) begin
      write_font(phase_font[p]);
      if (p == 4) quiet = 1'b1;
      counted = 0;
      while (counted < PHASE_ITEMS) begin
        c = random_cmd();
        enqueue(c);
        if (c.action == ACT_SET_CURSOR || c.character >= CH_SPACE ||
            c.character == CH_CR || c.character == CH_LF || c.character == CH_TAB)
          counted++;
      end
      drain();
    end

    if (mismatches == 0) begin
      $display("oled_text_cursor_engine_test: clean");
    end else begin
      $display("oled_text_cursor_engine_test: errors");
    end
    $finish;
  end

endmodule

/* oled_text_cursor_engine.f */
hdl/otce_pkg.sv
hdl/otce_alu.sv
hdl/otce_apb_regs.sv
hdl/otce_seq.sv
hdl/oled_text_cursor_engine.sv
test/oled_text_cursor_engine_test.sv
